// ===== rtl/line_follow_speed_controller_macros.svh =====
// Assertion macros for the speed controller checker.
`ifndef LINE_FOLLOW_SPEED_CONTROLLER_MACROS_SVH
`define LINE_FOLLOW_SPEED_CONTROLLER_MACROS_SVH

// same-cycle implication, ignored during reset
`define LFSC_CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfsc check failed");

// next-cycle implication, ignored during reset
`define LFSC_CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfsc check failed");

// next-cycle implication that also covers reset cycles
`define LFSC_CHK_NXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lfsc check failed");

`endif

// ===== rtl/lfsc_pkg.sv =====
`default_nettype none
package lfsc_pkg;

  localparam int IN_W       = 72;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // shared adder width: covers turn*half_track and speed*scale products
  localparam int ACC_W     = 54;
  localparam int NUM_W     = 34;   // quotient bits of the lateral term
  localparam int DIV_W     = 15;   // divisor (linear speed) bits
  localparam int MUL_STEPS = 16;   // multiplier operand bits
  localparam int CNT_W     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_POS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_TRACK  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SCALE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SCALE  = 3'd7;

  localparam logic signed [16:0] RAMP_UP    = 17'sd41;
  localparam logic signed [16:0] RAMP_DOWN  = 17'sd614;
  localparam logic signed [15:0] HEAD_LIMIT = 16'sd2859;
  localparam logic signed [15:0] LAT_LIMIT  = 16'sd1966;
  localparam logic signed [7:0]  BAD_LIMIT  = 8'sd3;

endpackage
`default_nettype wire

// ===== rtl/line_follow_speed_controller.sv =====
// Line-follow speed controller, one control tick per input item.
// Input stream s_*: tdata carries light level, heading error, lateral error,
// bad-fit count and x position. Output stream m_*: one result item per input
// item; tuser is drive_mode, tdata carries both wheel references and the
// race / odometry-reset flags. Config channel cfg_*: index and data, always
// ready; write it only while no item is in flight.
// With race mode off, the accept goes straight to the done state, which loads
// the output register. In race mode the shared 54-bit adder runs a 34-step
// restoring division of the lateral term by the speed, then three 16-step
// shift-add multiplies (turn * half track, right speed * scale, left speed *
// scale), before the done state. s_tready is high only while the sequencer is
// idle, so a new item is not taken until the last result has been loaded into
// the output register.
// The result sits in an output register; a new item is accepted while it
// waits, and the sequencer holds its finished result until m_tready frees
// the register. Reset loads register defaults, clears race/brake state and
// the previous errors, sets the speed to the start speed and empties the
// output register.
`default_nettype none
module line_follow_speed_controller (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // light[9:0], heading[25:10], lateral[41:26], bad_fit[49:42], pos_x[65:50]
  input  wire logic [lfsc_pkg::IN_W-1:0]        s_tdata,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // right_ref[13:0], left_ref[27:14], race_active[28], odometry_reset[29]
  output logic [lfsc_pkg::OUT_W-1:0]            m_tdata,
  // drive_mode[0]
  output logic                                  m_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic [lfsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready
);
  import lfsc_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_MUL_TT, ST_MUL_R, ST_MUL_L, ST_DONE} state_t;

  state_t state;

  logic [14:0] speed_max, speed_start, stop_position;
  logic [12:0] wheel_limit;
  logic [9:0]  light_threshold;
  logic [15:0] half_track, right_wheel_scale, left_wheel_scale;

  logic               race_flag, brake_flag;
  logic [14:0]        linear_speed;
  logic signed [15:0] prev_heading_error, prev_lateral_error;

  logic [CNT_W-1:0]        cnt;
  logic [DIV_W-1:0]        rem, dvsr;
  logic [NUM_W-1:0]        num;
  logic                    qneg;
  logic signed [25:0]      wpart;
  logic [14:0]             vn;
  logic signed [ACC_W-1:0] acc, mcand, s_left;
  logic [15:0]             mplier;
  logic [13:0]             res_right, res_left;
  logic                    res_drive, res_race, res_odo;

  // shared adder
  logic [ACC_W-1:0] alu_a, alu_b, alu_y;
  logic             alu_sub;

  // accept-time decode
  logic [9:0]         light;
  logic signed [15:0] eh, ey, px;
  logic signed [7:0]  bad;
  logic               trig, race_in, brake_cond, drop;
  logic signed [16:0] px_eff, v_dn, dh, dy;
  logic [15:0]        v_up;
  logic [14:0]        v_new;
  logic signed [20:0] lat;
  logic signed [35:0] prod, prod_abs;
  logic signed [25:0] wpart_in;

  // step results
  logic                    div_ok;
  logic [DIV_W-1:0]        rem_next;
  logic [NUM_W-1:0]        quot;
  logic signed [35:0]      w_full;
  logic signed [ACC_W-1:0] acc_next, tt_neg, s_right_in, s_left_in, v_ext;
  logic                    last_mul;

  function automatic logic [13:0] clamp_ref(input logic signed [ACC_W-1:0] p,
                                            input logic [12:0] lim);
    logic signed [ACC_W-1:0] r, lim_s;
    logic [13:0] res;
    r     = p >>> 16;
    lim_s = ACC_W'($signed({1'b0, lim}));
    if (r > lim_s) begin
      res = {1'b0, lim};
    end else if (r < -lim_s) begin
      res = 14'(-$signed({1'b0, lim}));
    end else begin
      res = r[13:0];
    end
    return res;
  endfunction

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign light = s_tdata[9:0];
  assign eh    = s_tdata[25:10];
  assign ey    = s_tdata[41:26];
  assign bad   = s_tdata[49:42];
  assign px    = s_tdata[65:50];

  always_comb begin
    trig       = light > light_threshold;
    race_in    = race_flag | trig;
    px_eff     = trig ? 17'sd0 : 17'(px);
    brake_cond = (px_eff > $signed({2'b00, stop_position})) || brake_flag;
    v_dn       = $signed({2'b00, linear_speed}) - RAMP_DOWN;
    v_up       = {1'b0, linear_speed} + 16'(RAMP_UP);
    if (brake_cond) begin
      if (v_dn > $signed({2'b00, speed_max})) begin
        v_new = speed_max;
      end else if (v_dn <= 17'sd0) begin
        v_new = '0;
      end else begin
        v_new = v_dn[14:0];
      end
    end else begin
      v_new = (v_up > {1'b0, speed_max}) ? speed_max : v_up[14:0];
    end
    drop = (bad > BAD_LIMIT) || (bad < -BAD_LIMIT) ||
           (eh > HEAD_LIMIT) || (eh < -HEAD_LIMIT) ||
           (ey > LAT_LIMIT) || (ey < -LAT_LIMIT) || (v_new == '0);

    dy       = 17'(ey) - 17'(prev_lateral_error);
    lat      = 21'(ey) + (21'(dy) <<< 2) + 21'(dy);
    prod     = (36'(lat) <<< 15) - (36'(lat) <<< 11);   // lat * 30720
    prod_abs = prod[35] ? -prod : prod;
    dh       = 17'(eh) - 17'(prev_heading_error);
    wpart_in = (26'(eh) <<< 1) + 26'(eh)
             + (26'(dh) <<< 7) + (26'(dh) <<< 6) + (26'(dh) <<< 3);
  end

  always_comb begin
    if (state == ST_DIV) begin
      alu_a   = ACC_W'({rem, num[NUM_W-1]});
      alu_b   = ACC_W'(dvsr);
      alu_sub = 1'b1;
    end else begin
      alu_a   = acc;
      alu_b   = mcand;
      alu_sub = 1'b0;
    end
    alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + ACC_W'(alu_sub);
  end

  always_comb begin
    div_ok   = ~alu_y[ACC_W-1];
    rem_next = div_ok ? alu_y[DIV_W-1:0] : {rem[DIV_W-2:0], num[NUM_W-1]};
    quot     = {num[NUM_W-2:0], div_ok};
    w_full   = 36'(wpart) + (qneg ? -36'(quot) : 36'(quot));
    acc_next = mplier[0] ? $signed(alu_y) : acc;
    last_mul = (cnt == CNT_W'(MUL_STEPS - 1));
    v_ext      = ACC_W'($signed({1'b0, vn}));
    tt_neg     = -acc_next;
    s_right_in = v_ext + (acc_next >>> 17);
    s_left_in  = v_ext + (tt_neg >>> 17);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      m_tvalid           <= 1'b0;
      speed_max          <= 15'd14336;
      speed_start        <= 15'd1934;
      wheel_limit        <= 13'd7200;
      light_threshold    <= 10'd800;
      stop_position      <= 15'd2304;
      half_track         <= '0;
      right_wheel_scale  <= '0;
      left_wheel_scale   <= '0;
      race_flag          <= 1'b0;
      brake_flag         <= 1'b0;
      linear_speed       <= 15'd1934;
      prev_heading_error <= '0;
      prev_lateral_error <= '0;
      cnt                <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SPEED_MAX:   speed_max         <= cfg_data[14:0];
          REG_SPEED_START: speed_start       <= cfg_data[14:0];
          REG_WHEEL_LIMIT: wheel_limit       <= cfg_data[12:0];
          REG_LIGHT_THR:   light_threshold   <= cfg_data[9:0];
          REG_STOP_POS:    stop_position     <= cfg_data[14:0];
          REG_HALF_TRACK:  half_track        <= cfg_data;
          REG_RIGHT_SCALE: right_wheel_scale <= cfg_data;
          REG_LEFT_SCALE:  left_wheel_scale  <= cfg_data;
          default: ;
        endcase
      end

      if (m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            res_odo <= trig;
            if (race_in) begin
              res_drive          <= 1'b1;
              res_race           <= ~drop;
              race_flag          <= ~drop;
              brake_flag         <= brake_cond;
              linear_speed       <= v_new;
              vn                 <= v_new;
              prev_heading_error <= eh;
              prev_lateral_error <= ey;
              dvsr               <= (linear_speed == '0) ? DIV_W'(1) : linear_speed;
              num                <= prod_abs[NUM_W-1:0];
              qneg               <= prod[35];
              rem                <= '0;
              wpart              <= wpart_in;
              cnt                <= '0;
              state              <= ST_DIV;
            end else begin
              res_drive <= 1'b0;
              res_race  <= 1'b0;
              res_right <= '0;
              res_left  <= '0;
              state     <= ST_DONE;
            end
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          num <= quot;
          if (cnt == CNT_W'(NUM_W - 1)) begin
            mcand  <= ACC_W'(w_full);
            mplier <= half_track;
            acc    <= '0;
            cnt    <= '0;
            state  <= ST_MUL_TT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_MUL_TT, ST_MUL_R, ST_MUL_L: begin
          if (last_mul) begin
            cnt <= '0;
            acc <= '0;
            if (state == ST_MUL_TT) begin
              s_left <= s_left_in;
              mcand  <= s_right_in;
              mplier <= right_wheel_scale;
              state  <= ST_MUL_R;
            end else if (state == ST_MUL_R) begin
              res_right <= clamp_ref(acc_next, wheel_limit);
              mcand     <= s_left;
              mplier    <= left_wheel_scale;
              state     <= ST_MUL_L;
            end else begin
              res_left <= clamp_ref(acc_next, wheel_limit);
              state    <= ST_DONE;
            end
          end else begin
            acc    <= acc_next;
            mcand  <= mcand <<< 1;
            mplier <= mplier >> 1;
            cnt    <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_drive;
            m_tdata  <= {2'b00, res_odo, res_race, res_left, res_right};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lfsc_checker.sv =====
`default_nettype none
`include "line_follow_speed_controller_macros.svh"
module lfsc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic                        m_tuser,
  input wire logic [lfsc_pkg::OUT_W-1:0]  m_tdata
);
  import lfsc_pkg::*;

  // a stalled result holds
  `LFSC_CHK_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // one item at a time: no back-to-back accepts
  `LFSC_CHK_NXT(a_one_item, s_tvalid && s_tready, !s_tready)
  // stopped motors report zero wheel refs
  `LFSC_CHK_IMP(a_stop_zero, m_tvalid && !m_tuser, m_tdata[27:0] == 28'd0)
  // odometry reset only fires together with race mode driving
  `LFSC_CHK_IMP(a_odo_drive, m_tvalid && m_tdata[29], m_tuser)
  // reset empties the output register
  `LFSC_CHK_NXT_ANY(a_rst_empty, rst, !m_tvalid)

endmodule

bind line_follow_speed_controller lfsc_checker u_lfsc_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_line_follow_speed_controller.sv =====
`default_nettype none
module tb_line_follow_speed_controller;
  import lfsc_pkg::*;

  typedef struct packed {
    logic [9:0]         light;
    logic signed [15:0] heading;
    logic signed [15:0] lateral;
    logic signed [7:0]  bad_fit;
    logic signed [15:0] pos_x;
  } tick_t;

  typedef struct packed {
    logic        drive;
    logic [13:0] right_ref;
    logic [13:0] left_ref;
    logic        race;
    logic        odo_reset;
  } wheel_cmd_t;

  typedef struct {
    tick_t      tick;
    bit         typed;
    wheel_cmd_t want;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic [IN_W-1:0]       s_tdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  cfg_valid;
  logic                  cfg_ready;

  line_follow_speed_controller DUT (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  // controller shadow: registers and race state
  longint ctl_reg [8];
  bit     race_on, brake_on;
  longint speed_now, prev_heading, prev_lateral;

  wheel_cmd_t cmd_q[$];
  int errors, ticks_sent, cmds_seen, race_ticks, brake_ticks, odo_pulses;
  int stall_cycles;
  bit held_once;
  int hold_left;

  function automatic longint wheel_speed_ref(longint v, longint turn, longint scale);
    longint s, r;
    s = (v * 131072 + turn) >>> 17;
    r = (s * scale) >>> 16;
    if (r > ctl_reg[REG_WHEEL_LIMIT]) r = ctl_reg[REG_WHEEL_LIMIT];
    else if (r < -ctl_reg[REG_WHEEL_LIMIT]) r = -ctl_reg[REG_WHEEL_LIMIT];
    return r;
  endfunction

  function automatic wheel_cmd_t control_tick(tick_t t);
    longint eh, ey, bad, px, v_old, dvs, lat, w, v, tt;
    wheel_cmd_t r;
    eh = t.heading; ey = t.lateral; bad = t.bad_fit; px = t.pos_x;
    r = '0;
    if (longint'(t.light) > ctl_reg[REG_LIGHT_THR]) begin
      race_on = 1; r.odo_reset = 1; px = 0;
    end
    if (race_on) begin
      v_old = speed_now;
      dvs = (v_old > 0) ? v_old : 1;
      lat = ey + 5 * (ey - prev_lateral);
      w = 3 * eh + 200 * (eh - prev_heading) + (30720 * lat) / dvs;
      v = v_old;
      if (px > ctl_reg[REG_STOP_POS] || brake_on) begin
        v -= 614;
        if (v > ctl_reg[REG_SPEED_MAX]) v = ctl_reg[REG_SPEED_MAX];
        else if (v <= 0) v = 0;
        brake_on = 1;
      end else begin
        v += 41;
        if (v > ctl_reg[REG_SPEED_MAX]) v = ctl_reg[REG_SPEED_MAX];
      end
      speed_now = v;
      tt = w * ctl_reg[REG_HALF_TRACK];
      r.right_ref = 14'(wheel_speed_ref(v, tt, ctl_reg[REG_RIGHT_SCALE]));
      r.left_ref  = 14'(wheel_speed_ref(v, -tt, ctl_reg[REG_LEFT_SCALE]));
      prev_heading = eh;
      prev_lateral = ey;
      if (bad > 3 || bad < -3) race_on = 0;
      else if (eh > 2859 || eh < -2859 || ey > 1966 || ey < -1966 || v == 0) race_on = 0;
      r.drive = 1;
    end
    r.race = race_on;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR cmd %0d: %s got %0d want %0d", cmds_seen, what, got, want);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // result side: check, then decide next ready
  always @(posedge clk) begin
    wheel_cmd_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{drive: m_tuser, right_ref: m_tdata[13:0], left_ref: m_tdata[27:14],
              race: m_tdata[28], odo_reset: m_tdata[29]};
      if (cmd_q.size() == 0) begin
        report_mismatch("unexpected item, drive", got.drive, 0);
      end else begin
        want = cmd_q.pop_front();
        if (got.drive != want.drive) report_mismatch("drive_mode", got.drive, want.drive);
        if (got.right_ref != want.right_ref)
          report_mismatch("right_ref", $signed(got.right_ref), $signed(want.right_ref));
        if (got.left_ref != want.left_ref)
          report_mismatch("left_ref", $signed(got.left_ref), $signed(want.left_ref));
        if (got.race != want.race) report_mismatch("race_active", got.race, want.race);
        if (got.odo_reset != want.odo_reset)
          report_mismatch("odometry_reset", got.odo_reset, want.odo_reset);
      end
      cmds_seen++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 0;
    end else if (!held_once && cmds_seen >= 700) begin
      held_once = 1;
      hold_left = 300;
      m_tready <= 0;
    end else begin
      m_tready <= (ticks_sent >= 400 && ticks_sent < 650) || ($urandom_range(99) >= 24);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_valid)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles == 3000) begin
      $display("line_follow_speed_controller: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    ctl_reg[idx] = val;
  endtask

  task automatic send_tick(tick_t t, bit typed, wheel_cmd_t want);
    wheel_cmd_t pred;
    s_tdata  <= {6'd0, t.pos_x, t.bad_fit, t.lateral, t.heading, t.light};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    pred = control_tick(t);
    cmd_q.push_back(typed ? want : pred);
    ticks_sent++;
    if (pred.drive) race_ticks++;
    if (brake_on) brake_ticks++;
    if (pred.odo_reset) odo_pulses++;
    if (!(ticks_sent >= 400 && ticks_sent < 650) && $urandom_range(99) < 24) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 130)) @(posedge clk);
    end
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_setup(longint smax, longint sstart, longint wlim, longint thr,
                            longint stop, longint ht, longint rs, longint ls);
    write_reg(REG_SPEED_MAX, smax);
    write_reg(REG_SPEED_START, sstart);
    write_reg(REG_WHEEL_LIMIT, wlim);
    write_reg(REG_LIGHT_THR, thr);
    write_reg(REG_STOP_POS, stop);
    write_reg(REG_HALF_TRACK, ht);
    write_reg(REG_RIGHT_SCALE, rs);
    write_reg(REG_LEFT_SCALE, ls);
    cfg_valid <= 0;
  endtask

  // mostly in-bounds ticks that keep race mode alive; the rest full-range noise
  task automatic random_run(int n);
    tick_t t;
    int thr;
    repeat (n) begin
      thr = int'(ctl_reg[REG_LIGHT_THR]);
      if ($urandom_range(99) < 80) begin
        t.light   = (thr < 1023 && $urandom_range(99) < 8) ? 10'($urandom_range(1023, thr + 1))
                                                           : 10'($urandom_range(thr, 0));
        t.heading = 16'($signed($urandom_range(5718)) - 2859);
        t.lateral = 16'($signed($urandom_range(3932)) - 1966);
        t.bad_fit = 8'($signed($urandom_range(6)) - 3);
        t.pos_x   = 16'($urandom_range(32767));
      end else begin
        t = tick_t'(66'({$urandom(), $urandom(), $urandom()}));
      end
      send_tick(t, 0, '0);
    end
  endtask

  initial begin
    dir_row_t rows [$];
    s_tvalid = 0; s_tdata = '0; m_tready = 0;
    cfg_index = '0; cfg_data = '0; cfg_valid = 0;
    ctl_reg = '{14336, 1934, 7200, 800, 2304, 0, 0, 0};
    race_on = 0; brake_on = 0; speed_now = 1934; prev_heading = 0; prev_lateral = 0;
    rst = 1;
    repeat (12) @(posedge clk);
    rst <= 0;

    rows = '{
      // idle after reset: motors stopped
      '{'{10'd0, 16'sd0, 16'sd0, 8'sd0, 16'sd0}, 1, '0},
      '{'{10'd800, -16'sd32768, 16'sd32767, -8'sd128, 16'sd32767}, 1, '0},
      '{'{10'd1023, 16'sd0, 16'sd0, 8'sd0, 16'sd100}, 0, '0},
      '{'{10'd0, 16'sd100, -16'sd200, 8'sd0, 16'sd0}, 0, '0},
      '{'{10'd0, 16'sd2859, 16'sd1966, 8'sd3, 16'sd50}, 0, '0},
      '{'{10'd0, -16'sd2859, -16'sd1966, -8'sd3, -16'sd32768}, 0, '0},
      '{'{10'd0, 16'sd2860, 16'sd0, 8'sd0, 16'sd0}, 0, '0},
      '{'{10'd801, 16'sd0, 16'sd0, 8'sd0, 16'sd0}, 0, '0},
      '{'{10'd0, 16'sd0, 16'sd0, -8'sd4, 16'sd0}, 0, '0},
      '{'{10'd900, 16'sd5, 16'sd0, 8'sd0, 16'sd0}, 0, '0},
      '{'{10'd0, 16'sd0, -16'sd1967, 8'sd0, 16'sd0}, 0, '0},
      '{'{10'd1023, 16'sd32767, 16'sd32767, 8'sd127, 16'sd32767}, 0, '0},
      '{'{10'd1023, -16'sd32768, -16'sd32768, -8'sd128, -16'sd1}, 0, '0},
      '{'{10'd1000, 16'sd1000, 16'sd1500, 8'sd1, 16'sd10}, 0, '0},
      '{'{10'd0, -16'sd1000, -16'sd1500, -8'sd1, 16'sd20}, 0, '0},
      '{'{10'd0, 16'sd0, 16'sd0, 8'sd0, 16'sd0}, 0, '0}
    };

    load_setup(14336, 1934, 7200, 800, 32767, 3000, 4000, 4100);
    foreach (rows[i]) send_tick(rows[i].tick, rows[i].typed, rows[i].want);
    random_run(270);
    drain();
    load_setup(32767, 0, 8191, 0, 32767, 65535, 65535, 65535);
    random_run(270);
    drain();
    // zero maximum: speed collapses and the divisor falls back to one
    load_setup(0, 32767, 0, 200, 32767, 0, 0, 0);
    random_run(60);
    drain();
    load_setup(20000, 1000, 6000, 700, 32767, 4500, 9000, 8800);
    random_run(320);
    drain();
    load_setup($urandom_range(32767), $urandom_range(32767), $urandom_range(8191),
               $urandom_range(1023), 32767, $urandom_range(65535),
               $urandom_range(65535), $urandom_range(65535));
    random_run(150);
    drain();
    // low stop position: braking latches and speed ramps down to zero
    load_setup(12000, 1934, 7000, 600, 400, 3000, 5000, 5000);
    random_run(270);
    drain();

    $display("covered %0d ticks: %0d in race mode, %0d odometry resets, %0d while braking",
             ticks_sent, race_ticks, odo_pulses, brake_ticks);
    $display("six register setups incl. full-scale and zero speed limit, one 300-cycle stall");
    if (errors == 0) begin
      $display("line_follow_speed_controller: match");
    end else begin
      $display("line_follow_speed_controller: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
